### rtl/thermal_derating_pi_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thermal derating PI controller
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THERMAL_DERATING_PI_CONTROLLER_ASSERT_SVH
`define THERMAL_DERATING_PI_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define TDPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// tdpc_pkg
// Shared types and constants of the thermal derating PI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpc_pkg;

    localparam int QW        = 32;
    localparam int FRAC      = 16;
    localparam int GAIN_W    = 19;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [QW-1:0] Q_ONE         = 32'sd65536;
    localparam logic [GAIN_W-1:0]    GAIN_CLAMP_LO = 19'd65536;
    localparam logic [GAIN_W-1:0]    GAIN_CLAMP_HI = 19'd327680;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN       = 3'd0,
        REG_INTEG_GAIN_STEP = 3'd1,
        REG_DRIVE_MIN       = 3'd2,
        REG_DRIVE_MAX       = 3'd3,
        REG_INTEG_PRESET    = 3'd4,
        REG_TEMP_REF        = 3'd5,
        REG_CURRENT_NOMINAL = 3'd6,
        REG_ACTIVATE_TEMP   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_ERR   = 2'd0,
        MUL_PROP  = 2'd1,
        MUL_INTEG = 2'd2
    } mul_sel_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_MULE = 9'b000001000,
        S_ERR  = 9'b000010000,
        S_MULP = 9'b000100000,
        S_MULI = 9'b001000000,
        S_SUM  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic     load;
        logic     prep;
        logic     div_step;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     err_en;
        logic     p_en;
        logic     sum_en;
        logic     fin;
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/thermal_derating_pi_controller.sv
// ----------------------------------------------------------------------------
// thermal_derating_pi_controller
// Temperature-error PI controller with current-scaled error and anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one item = junction temperature and load current.
//   Output stream m_axis: one item = drive (tdata) and bypassed flag (tuser).
//   Config port: cfg_we/cfg_index/cfg_data; the user writes it only while idle,
//   which the block does not enforce; a preset write also loads the integrator.
// Timing:
//   An item goes from acceptance through prep, the 19-step serial divider
//   (only when the coupling gain needs it), the error, proportional and
//   integral multiplies and the sum to the output register. s_axis_tready is
//   high only in the idle state, so a new item is taken only after the
//   previous result is loaded; the multiplies share one 33x33 multiplier.
// Reset:
//   Config registers and integrator go to their defaults, no result pending.
// Stall:
//   A result waits in the output register; the next item is still accepted
//   and processed, then holds before its final step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_derating_pi_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] junction_temp, [63:32] load_current
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] drive
    output logic [0:0]       m_axis_tuser,   // [0] bypassed
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    tdpc_pkg::dp_cmd_t  cmd;
    tdpc_pkg::dp_sts_t  sts;
    logic signed [31:0] drive;
    logic               bypassed;

    tdpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdpc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .junction_temp (s_axis_tdata[31:0]),
        .load_current  (s_axis_tdata[63:32]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .drive         (drive),
        .bypassed      (bypassed)
    );

    assign m_axis_tdata    = drive;
    assign m_axis_tuser[0] = bypassed;

endmodule

`default_nettype wire

### rtl/tdpc_dp.sv
// ----------------------------------------------------------------------------
// tdpc_dp
// Datapath: config registers, coupling-gain divider, shared multiplier,
// PI integrator with anti-windup, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tdpc_pkg::dp_cmd_t     cmd,
    output tdpc_pkg::dp_sts_t          sts,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic signed [31:0]    junction_temp,
    input  wire logic signed [31:0]    load_current,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         drive,
    output logic                       bypassed
);

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [31:0] r;
        if (x > 50'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -50'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    logic signed [31:0] prop_gain_reg, igs_reg, dmin_reg, dmax_reg;
    logic signed [31:0] temp_ref_reg, nom_reg, act_reg, integ_reg;

    logic signed [31:0] tj_reg, cur_reg;
    logic signed [32:0] diff_reg;
    logic               byp_reg;
    logic [tdpc_pkg::GAIN_W-1:0] gain_reg;
    logic [30:0]        rem_reg;
    logic [tdpc_pkg::GAIN_W-1:0] dvd_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] err_reg;
    logic signed [47:0] p_reg;
    logic signed [31:0] isum_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_drive_reg;
    logic               out_byp_reg;

    // config registers; a preset write also loads the integrator
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prop_gain_reg <= 32'sd65536;
            igs_reg       <= 32'sd0;
            dmin_reg      <= 32'sd0;
            dmax_reg      <= 32'sd65536;
            temp_ref_reg  <= 32'sd8192000;
            nom_reg       <= 32'sd65536;
            act_reg       <= 32'sd6553600;
        end else if (cfg_we) begin
            case (tdpc_pkg::cfg_idx_t'(cfg_index))
                tdpc_pkg::REG_PROP_GAIN:       prop_gain_reg <= cfg_data;
                tdpc_pkg::REG_INTEG_GAIN_STEP: igs_reg       <= cfg_data;
                tdpc_pkg::REG_DRIVE_MIN:       dmin_reg      <= cfg_data;
                tdpc_pkg::REG_DRIVE_MAX:       dmax_reg      <= cfg_data;
                tdpc_pkg::REG_TEMP_REF:        temp_ref_reg  <= cfg_data;
                tdpc_pkg::REG_CURRENT_NOMINAL: nom_reg       <= cfg_data;
                tdpc_pkg::REG_ACTIVATE_TEMP:   act_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // gain selection and gates
    logic signed [34:0] cur_x, cur5, nom_x;
    logic               gain_is_max, gain_is_min, need_div;

    always_comb begin
        cur_x       = 35'(cur_reg);
        cur5        = (cur_x <<< 2) + cur_x;
        nom_x       = 35'(nom_reg);
        gain_is_max = 1'b0;
        gain_is_min = 1'b0;
        need_div    = 1'b0;
        if (cur_reg == 32'sd0)
            gain_is_max = 1'b1;
        else if (cur_reg[31])
            gain_is_min = 1'b1;
        else if (nom_x >= cur5)
            gain_is_max = 1'b1;
        else if (nom_reg < cur_reg)
            gain_is_min = 1'b1;
        else
            need_div = 1'b1;
    end

    // restoring divide step: quotient bits shift into gain_reg
    logic [31:0] r2;
    logic        q_bit;

    always_comb begin
        r2    = {1'b0, rem_reg} + {31'd0, 1'b0};
        r2    = {rem_reg, dvd_reg[tdpc_pkg::GAIN_W-1]};
        q_bit = (r2 >= {1'b0, cur_reg[30:0]});
    end

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;

    always_comb begin
        case (cmd.mul_sel)
            tdpc_pkg::MUL_ERR:
            begin
                mul_a = diff_reg;
                mul_b = $signed({14'd0, gain_reg});
            end
            tdpc_pkg::MUL_PROP:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(prop_gain_reg);
            end
            tdpc_pkg::MUL_INTEG:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(igs_reg);
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    // final sum, clamp, anti-windup, bypass override to Q_ONE
    logic signed [48:0] u;
    logic signed [48:0] dmax_x, dmin_x;
    logic signed [31:0] drv, integ_next;

    always_comb begin
        u          = 49'(p_reg) + 49'(isum_reg);
        dmax_x     = 49'(dmax_reg);
        dmin_x     = 49'(dmin_reg);
        integ_next = isum_reg;
        drv        = u[31:0];
        if (u > dmax_x) begin
            drv = dmax_reg;
            if (err_reg > 32'sd0)
                integ_next = integ_reg;
        end else if (u < dmin_x) begin
            drv = dmin_reg;
            if (err_reg < 32'sd0)
                integ_next = integ_reg;
        end
        if (byp_reg)
            drv = tdpc_pkg::Q_ONE;
    end

    // work registers
    always_ff @(posedge clk) begin
        if (cmd.load) begin
            tj_reg  <= junction_temp;
            cur_reg <= load_current;
        end
        if (cmd.prep) begin
            diff_reg <= 33'(temp_ref_reg) - 33'(tj_reg);
            byp_reg  <= (tj_reg < act_reg) || (cur5 < nom_x);
            rem_reg  <= {3'd0, nom_reg[30:3]};
            dvd_reg  <= {nom_reg[2:0], 16'd0};
            if (gain_is_max)
                gain_reg <= tdpc_pkg::GAIN_CLAMP_HI;
            else if (gain_is_min)
                gain_reg <= tdpc_pkg::GAIN_CLAMP_LO;
            else
                gain_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= q_bit ? 31'(r2 - {1'b0, cur_reg[30:0]}) : r2[30:0];
            gain_reg <= {gain_reg[tdpc_pkg::GAIN_W-2:0], q_bit};
            dvd_reg  <= {dvd_reg[tdpc_pkg::GAIN_W-2:0], 1'b0};
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.err_en)
            err_reg <= sat32($signed(prod_reg[65:16]));
        if (cmd.p_en)
            p_reg <= $signed(prod_reg[63:16]);
        if (cmd.sum_en)
            isum_reg <= sat32(50'(integ_reg) + 50'($signed(prod_reg[63:16])));
        if (cmd.fin) begin
            out_drive_reg <= drv;
            out_byp_reg   <= byp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            integ_reg <= tdpc_pkg::Q_ONE;
        else if (cfg_we && (tdpc_pkg::cfg_idx_t'(cfg_index) == tdpc_pkg::REG_INTEG_PRESET))
            integ_reg <= cfg_data;
        else if (cmd.fin)
            integ_reg <= integ_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.fin)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign sts.need_div = need_div;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign drive        = out_drive_reg;
    assign bypassed     = out_byp_reg;

endmodule

`default_nettype wire

### rtl/tdpc_ctrl.sv
// ----------------------------------------------------------------------------
// tdpc_ctrl
// Sequencer: steps one item through gain, divide (when needed), multiply and update.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tdpc_pkg::dp_sts_t  sts,
    output tdpc_pkg::dp_cmd_t       cmd
);

    tdpc_pkg::state_t state_reg, state_next;
    logic [tdpc_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= tdpc_pkg::S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.mul_sel = tdpc_pkg::MUL_ERR;
        in_ready    = 1'b0;
        case (state_reg)
            tdpc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = tdpc_pkg::S_PREP;
                end
            end
            tdpc_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = sts.need_div ? tdpc_pkg::S_DIV : tdpc_pkg::S_MULE;
            end
            tdpc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + tdpc_pkg::CNT_W'(1);
                if (cnt_reg == tdpc_pkg::CNT_W'(tdpc_pkg::DIV_STEPS - 1))
                    state_next = tdpc_pkg::S_MULE;
            end
            tdpc_pkg::S_MULE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tdpc_pkg::MUL_ERR;
                state_next  = tdpc_pkg::S_ERR;
            end
            tdpc_pkg::S_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = tdpc_pkg::S_MULP;
            end
            tdpc_pkg::S_MULP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tdpc_pkg::MUL_PROP;
                state_next  = tdpc_pkg::S_MULI;
            end
            tdpc_pkg::S_MULI:
            begin
                cmd.p_en    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tdpc_pkg::MUL_INTEG;
                state_next  = tdpc_pkg::S_SUM;
            end
            tdpc_pkg::S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = tdpc_pkg::S_FIN;
            end
            tdpc_pkg::S_FIN:
            begin
                // hold until the output register can take the item
                if (sts.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = tdpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tdpc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/tdpc_checker.sv
// ----------------------------------------------------------------------------
// tdpc_checker
// Port-level checks of the thermal derating PI controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thermal_derating_pi_controller_assert.svh"

module tdpc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    `TDPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `TDPC_ASSERT_SAME(a_byp_one, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == tdpc_pkg::Q_ONE, "bypassed result is not 1.0")
    `TDPC_ASSERT_NEXT(a_one_item, in_acc, !s_axis_tready, "second item taken while busy")
    `TDPC_ASSERT_NEXT(a_no_early, in_acc, !$rose(m_axis_tvalid), "result appeared too early")

endmodule

bind thermal_derating_pi_controller tdpc_checker u_chk (.*);

`default_nettype wire
